>>> hdl/zstp_pkg.sv
// Shared types for the zoomed sprite tile placer.
package zstp_pkg;

    localparam int unsigned CoordW = 9;
    localparam int unsigned SizeW  = 3;
    localparam int unsigned ZoomW  = 6;
    localparam int unsigned AddrW  = 17;
    localparam int unsigned PalW   = 6;
    localparam int unsigned MaskW  = 8;

    // priority codes and their layer masks
    localparam logic [1:0] PriNone = 2'd0;
    localparam logic [1:0] PriLow  = 2'd1;
    localparam logic [1:0] PriMid  = 2'd2;
    localparam logic [1:0] PriHigh = 2'd3;

    localparam logic [MaskW-1:0] MaskNone = 8'h00;
    localparam logic [MaskW-1:0] MaskLow  = 8'hf0;
    localparam logic [MaskW-1:0] MaskMid  = 8'hfc;
    localparam logic [MaskW-1:0] MaskHigh = 8'hfe;

    // decoded sprite, origin already centred and reduced modulo 512
    typedef struct packed {
        logic [CoordW-1:0] org_x;
        logic [CoordW-1:0] org_y;
        logic [SizeW-1:0]  size_x;
        logic [SizeW-1:0]  size_y;
        logic [ZoomW-1:0]  zoom_x;
        logic [ZoomW-1:0]  zoom_y;
        logic              flip_x;
        logic              flip_y;
        logic [PalW-1:0]   palette;
        logic [MaskW-1:0]  pmask;
        logic [AddrW-1:0]  map_addr;
    } t_sprite;

    // one tile on its way to the placement stage
    typedef struct packed {
        logic [CoordW-1:0] org_x;
        logic [CoordW-1:0] org_y;
        logic [SizeW-1:0]  idx_x;
        logic [SizeW-1:0]  idx_y;
        logic [ZoomW-1:0]  zoom_x;
        logic [ZoomW-1:0]  zoom_y;
        logic              flip_x;
        logic              flip_y;
        logic [PalW-1:0]   palette;
        logic [MaskW-1:0]  pmask;
        logic [AddrW-1:0]  map_addr;
        logic              last;
    } t_tile;

    function automatic logic [MaskW-1:0] pri_mask(input logic [1:0] pri);
        logic [MaskW-1:0] m;
        unique case (pri)
            PriNone: m = MaskNone;
            PriLow:  m = MaskLow;
            PriMid:  m = MaskMid;
            PriHigh: m = MaskHigh;
            default: m = MaskNone;
        endcase
        return m;
    endfunction

endpackage

>>> hdl/zstp_if.sv
// Valid/ready channel interfaces for sprite input and tile placement output.
interface zstp_in_if;
    logic        valid;
    logic        ready;
    logic        sprite_off;
    logic [15:0] pos_y_word;
    logic [15:0] pos_x_word;
    logic [15:0] style_word;
    logic [15:0] map_word;

    modport source (output valid, sprite_off, pos_y_word, pos_x_word, style_word, map_word,
                    input ready);
    modport sink   (input valid, sprite_off, pos_y_word, pos_x_word, style_word, map_word,
                    output ready);
endinterface

interface zstp_out_if;
    logic              valid;
    logic              ready;
    logic signed [9:0] draw_x;
    logic signed [9:0] draw_y;
    logic [16:0]       tile_map_address;
    logic [5:0]        palette;
    logic              flip_x;
    logic              flip_y;
    logic [5:0]        zoom_x;
    logic [5:0]        zoom_y;
    logic [7:0]        layer_mask;
    logic              last_tile;

    modport source (output valid, draw_x, draw_y, tile_map_address, palette, flip_x, flip_y,
                    zoom_x, zoom_y, layer_mask, last_tile,
                    input ready);
    modport sink   (input valid, draw_x, draw_y, tile_map_address, palette, flip_x, flip_y,
                    zoom_x, zoom_y, layer_mask, last_tile,
                    output ready);
endinterface

>>> hdl/zstp_seq.sv
// Tile sequencer: walks a sprite's tiles row by row, one per transfer.
module zstp_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_spr_vld,
    input  zstp_pkg::t_sprite i_spr,
    output logic              o_spr_rdy,
    output logic              o_tile_vld,
    output zstp_pkg::t_tile   o_tile,
    input  logic              i_tile_rdy
);

    logic                            r_busy;
    zstp_pkg::t_sprite               r_spr;
    logic [zstp_pkg::SizeW-1:0]      r_x;
    logic [zstp_pkg::SizeW-1:0]      r_y;
    logic [zstp_pkg::AddrW-1:0]      r_addr;
    logic                            row_end;
    logic                            last;
    logic                            fire;

    always_comb begin
        row_end    = (r_x == r_spr.size_x);
        last       = row_end && (r_y == r_spr.size_y);
        fire       = r_busy && i_tile_rdy;
        o_spr_rdy  = !r_busy || (fire && last);
        o_tile_vld = r_busy;

        o_tile.org_x    = r_spr.org_x;
        o_tile.org_y    = r_spr.org_y;
        // flipped axis walks positions backwards, address still forwards
        o_tile.idx_x    = r_spr.flip_x ? (r_spr.size_x - r_x) : r_x;
        o_tile.idx_y    = r_spr.flip_y ? (r_spr.size_y - r_y) : r_y;
        o_tile.zoom_x   = r_spr.zoom_x;
        o_tile.zoom_y   = r_spr.zoom_y;
        o_tile.flip_x   = r_spr.flip_x;
        o_tile.flip_y   = r_spr.flip_y;
        o_tile.palette  = r_spr.palette;
        o_tile.pmask    = r_spr.pmask;
        o_tile.map_addr = r_addr;
        o_tile.last     = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_spr_rdy) begin
            r_busy <= i_spr_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_spr_rdy && i_spr_vld) begin
            r_spr  <= i_spr;
            r_x    <= '0;
            r_y    <= '0;
            r_addr <= i_spr.map_addr;
        end else if (fire) begin
            r_addr <= r_addr + zstp_pkg::AddrW'(2);
            if (row_end) begin
                r_x <= '0;
                r_y <= r_y + 1'b1;
            end else begin
                r_x <= r_x + 1'b1;
            end
        end
    end

endmodule

>>> hdl/zoomed_sprite_tile_placer_top.sv
// Sprite tile placer top level: decode, tile sequencer, tile register, placement output.
// The first placement of a sprite passes the decode register, the sequencer, the tile register and the
// output register, each of which can stall. Throughput: one placement per cycle while the output is not
// stalled; a sprite of W x H tiles (1 to 64) holds the tile sequencer for W*H transfers, which sets the input rate.
// A disabled sprite is taken at stage A and yields nothing.
// Reset (synchronous, active low) empties every stage; payload registers keep their data.
module zoomed_sprite_tile_placer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    zstp_in_if.sink     i_in,
    zstp_out_if.source  o_out
);

    // ---------------------------------------------------------------
    // Stage A: attribute decode and origin centring
    // ---------------------------------------------------------------
    logic              r_a_vld;
    zstp_pkg::t_sprite r_a;
    zstp_pkg::t_sprite n_a;
    logic              a_take;
    logic              seq_in_rdy;

    logic [2:0] sz_x, sz_y;
    logic [3:0] zf_x, zf_y;
    logic [7:0] cen_x, cen_y;   // size * zoom + 2, at most 107

    always_comb begin
        sz_x  = i_in.pos_x_word[11:9];
        sz_y  = i_in.pos_y_word[11:9];
        zf_x  = i_in.pos_x_word[15:12];
        zf_y  = i_in.pos_y_word[15:12];
        cen_x = {5'd0, sz_x} * {4'd0, zf_x} + 8'd2;
        cen_y = {5'd0, sz_y} * {4'd0, zf_y} + 8'd2;

        // only the low nine bits of the origin survive the later wrap
        n_a.org_x    = i_in.pos_x_word[8:0] + 9'(cen_x[7:2]);
        n_a.org_y    = i_in.pos_y_word[8:0] + 9'd1 + 9'(cen_y[7:2]);
        n_a.size_x   = sz_x;
        n_a.size_y   = sz_y;
        n_a.zoom_x   = 6'd32 - 6'(zf_x);
        n_a.zoom_y   = 6'd32 - 6'(zf_y);
        n_a.flip_x   = i_in.style_word[14];
        n_a.flip_y   = i_in.style_word[15];
        n_a.palette  = i_in.style_word[13:8];
        n_a.pmask    = zstp_pkg::pri_mask(i_in.style_word[13:12]);
        n_a.map_addr = {1'b0, i_in.map_word[14:0], 1'b0};
    end

    assign a_take     = !r_a_vld || seq_in_rdy;
    assign i_in.ready = a_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (a_take) begin
            // a disabled sprite is consumed here and goes no further
            r_a_vld <= i_in.valid && !i_in.sprite_off;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_take && i_in.valid) begin
            r_a <= n_a;
        end
    end

    // ---------------------------------------------------------------
    // Stage B: tile sequencer
    // ---------------------------------------------------------------
    logic            seq_vld;
    zstp_pkg::t_tile seq_tile;
    logic            c_take;

    zstp_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_spr_vld  (r_a_vld),
        .i_spr      (r_a),
        .o_spr_rdy  (seq_in_rdy),
        .o_tile_vld (seq_vld),
        .o_tile     (seq_tile),
        .i_tile_rdy (c_take)
    );

    // ---------------------------------------------------------------
    // Stage C: tile register
    // ---------------------------------------------------------------
    logic            r_c_vld;
    zstp_pkg::t_tile r_c;
    logic            d_take;

    assign c_take = !r_c_vld || d_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (c_take) begin
            r_c_vld <= seq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_take && seq_vld) begin
            r_c <= seq_tile;
        end
    end

    // ---------------------------------------------------------------
    // Stage D: scaled offset, 9-bit wrap, output register
    // ---------------------------------------------------------------
    logic        r_d_vld;
    logic [8:0]  prod_x, prod_y;   // zoom * index, at most 224
    logic [8:0]  wrap_x, wrap_y;

    always_comb begin
        prod_x = 9'(r_c.zoom_x) * 9'(r_c.idx_x);
        prod_y = 9'(r_c.zoom_y) * 9'(r_c.idx_y);
        wrap_x = r_c.org_x + (prod_x >> 1) + 9'd16;
        wrap_y = r_c.org_y + (prod_y >> 1) + 9'd16;
    end

    assign d_take      = !r_d_vld || o_out.ready;
    assign o_out.valid = r_d_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (d_take) begin
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (d_take && r_c_vld) begin
            o_out.draw_x           <= $signed({1'b0, wrap_x} - 10'd16);
            o_out.draw_y           <= $signed({1'b0, wrap_y} - 10'd16);
            o_out.tile_map_address <= r_c.map_addr;
            o_out.palette          <= r_c.palette;
            o_out.flip_x           <= r_c.flip_x;
            o_out.flip_y           <= r_c.flip_y;
            o_out.zoom_x           <= r_c.zoom_x;
            o_out.zoom_y           <= r_c.zoom_y;
            o_out.layer_mask       <= r_c.pmask;
            o_out.last_tile        <= r_c.last;
        end
    end

`ifndef SYNTHESIS
    a_off_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.sprite_off) |=> !r_a_vld)
        else $error("disabled sprite entered the decode stage");

    a_zoom_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_vld |-> (r_c.zoom_x >= 6'd17 && r_c.zoom_x <= 6'd32 &&
                     r_c.zoom_y >= 6'd17 && r_c.zoom_y <= 6'd32))
        else $error("tile zoom out of range");

    a_draw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.draw_x >= -10'sd16 && o_out.draw_y >= -10'sd16))
        else $error("placement below wrapped screen range");
`endif

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the zoomed sprite tile placer: driver, tile monitor and predictor.
module testbench;

    // run shape
    localparam int unsigned RandomSprites = 405;   // enabled sprites in the random part
    localparam int unsigned PauseEvery    = 110;   // sender drains the block this often
    localparam int unsigned HoldCycles    = 200;   // long receiver hold-off
    localparam int unsigned TailCycles    = 16;    // settle time after the last placement
    localparam int unsigned LimitCycles   = 500_000;

    // one sprite as presented on the input channel, or a drain marker
    typedef struct {
        logic        pause;
        logic        off;
        logic [15:0] yw;
        logic [15:0] xw;
        logic [15:0] sw;
        logic [15:0] mw;
    } t_entry;

    // one expected tile placement
    typedef struct {
        logic signed [9:0]          x;
        logic signed [9:0]          y;
        logic [zstp_pkg::AddrW-1:0] addr;
        logic [zstp_pkg::PalW-1:0]  pal;
        logic                       fx;
        logic                       fy;
        logic [zstp_pkg::ZoomW-1:0] zx;
        logic [zstp_pkg::ZoomW-1:0] zy;
        logic [zstp_pkg::MaskW-1:0] mask;
        logic                       last;
    } t_placement;

    logic i_clk;
    logic i_rst_n;

    zstp_in_if  in_ch ();
    zstp_out_if out_ch ();

    zoomed_sprite_tile_placer_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_entry      pending[$];     // sprites and drain markers still to be offered
    t_placement  tiles_due[$];   // placements predicted but not yet seen
    t_entry      on_offer;       // sprite currently held on the input channel

    int unsigned sprites_queued = 0;
    int unsigned sprites_taken  = 0;
    int unsigned tiles_seen     = 0;
    int unsigned errors         = 0;
    int unsigned cycles         = 0;
    int unsigned hold_left      = 0;
    int unsigned next_hold      = 0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // position along one axis: wrapped to 9 bits with a 16 pixel margin
    function automatic logic signed [9:0] screen_coord(input int unsigned org,
                                                       input int unsigned scale,
                                                       input int unsigned idx);
        logic [8:0] wrapped;
        wrapped = 9'(org + (scale * idx) / 2 + 16);
        return {1'b0, wrapped} - 10'd16;
    endfunction

    // expands one transferred sprite into its tile placements, row by row
    function automatic void place_sprite(input t_entry s);
        int unsigned                org_x, org_y, cols, rows, scale_x, scale_y, addr, ix, iy;
        logic [zstp_pkg::MaskW-1:0] mask;
        t_placement                 p;
        if (s.off)
            return;
        cols    = 32'(s.xw[11:9]);
        rows    = 32'(s.yw[11:9]);
        scale_x = 32'(s.xw[15:12]);
        scale_y = 32'(s.yw[15:12]);
        // origin pushed by the zoom centring term; y origin sits one line lower
        org_x   = 32'(s.xw[8:0]) + (cols * scale_x + 2) / 4;
        org_y   = 32'(s.yw[8:0]) + 1 + (rows * scale_y + 2) / 4;
        scale_x = 32 - scale_x;
        scale_y = 32 - scale_y;
        addr    = 32'({s.mw[14:0], 1'b0});
        case (s.sw[13:12])
            zstp_pkg::PriLow:  mask = zstp_pkg::MaskLow;
            zstp_pkg::PriMid:  mask = zstp_pkg::MaskMid;
            zstp_pkg::PriHigh: mask = zstp_pkg::MaskHigh;
            default:           mask = zstp_pkg::MaskNone;
        endcase
        for (iy = 0; iy <= rows; iy++) begin
            for (ix = 0; ix <= cols; ix++) begin
                // a flipped axis walks positions backwards; map address still goes forwards
                p.x    = screen_coord(org_x, scale_x, s.sw[14] ? cols - ix : ix);
                p.y    = screen_coord(org_y, scale_y, s.sw[15] ? rows - iy : iy);
                p.addr = addr[zstp_pkg::AddrW-1:0];
                p.pal  = s.sw[13:8];
                p.fx   = s.sw[14];
                p.fy   = s.sw[15];
                p.zx   = scale_x[zstp_pkg::ZoomW-1:0];
                p.zy   = scale_y[zstp_pkg::ZoomW-1:0];
                p.mask = mask;
                p.last = (iy == rows) && (ix == cols);
                tiles_due.push_back(p);
                addr += 2;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_sprite(input logic off, input logic [15:0] yw, input logic [15:0] xw,
                                input logic [15:0] sw, input logic [15:0] mw);
        t_entry s;
        s = '{pause: 1'b0, off: off, yw: yw, xw: xw, sw: sw, mw: mw};
        pending.push_back(s);
        sprites_queued++;
    endtask

    task automatic queue_pause();
        t_entry s;
        s = '{pause: 1'b1, off: 1'b0, yw: '0, xw: '0, sw: '0, mw: '0};
        pending.push_back(s);
    endtask

    // random axis word; size kept small most of the time to keep the run short
    function automatic logic [15:0] rand_axis_word();
        logic [15:0] w;
        w = 16'($urandom);
        w[11:9] = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(3));
        return w;
    endfunction

    // idle percentage per side: first sender light / receiver heavy, then swapped, then none
    function automatic int unsigned idle_pct(input bit receiver);
        int unsigned phase;
        phase = (sprites_taken * 3) / sprites_queued;
        if (phase == 0)
            return receiver ? 49 : 19;
        else if (phase == 1)
            return receiver ? 19 : 49;
        return 0;
    endfunction

    task automatic flag_error(input string msg);
        errors++;
        $display("ERROR cycle %0d tile %0d: %s", cycles, tiles_seen, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            flag_error($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Clock, watchdog
    // ------------------------------------------------------------------

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // hard stop well beyond the slowest legal run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LimitCycles) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sprite driver: offers the head of the pending queue, holds it until the transfer,
    // and predicts the placements at the transfer edge. A drain marker holds the
    // sender off until every predicted placement has arrived.
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin : sprite_driver
        logic offer;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            offer = in_ch.valid;
            if (in_ch.valid && in_ch.ready) begin
                place_sprite(on_offer);
                sprites_taken++;
                offer = 1'b0;
            end
            if (!offer) begin
                if (pending.size() != 0 && pending[0].pause && tiles_due.size() == 0)
                    void'(pending.pop_front());
                if (pending.size() != 0 && !pending[0].pause
                        && $urandom_range(99) >= idle_pct(1'b0)) begin
                    on_offer = pending.pop_front();
                    offer    = 1'b1;
                    in_ch.sprite_off <= on_offer.off;
                    in_ch.pos_y_word <= on_offer.yw;
                    in_ch.pos_x_word <= on_offer.xw;
                    in_ch.style_word <= on_offer.sw;
                    in_ch.map_word   <= on_offer.mw;
                end
            end
            in_ch.valid <= offer;
        end
    end

    // ------------------------------------------------------------------
    // Placement receiver: random stalls, plus two long hold-offs so the block backs up
    // and stalls its input while the sender keeps offering.
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin : tile_receiver
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else if (next_hold < 2 && sprites_taken >=
                     (next_hold == 0 ? sprites_queued / 8 : (sprites_queued * 3) / 4)) begin
            hold_left = HoldCycles;
            next_hold++;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= idle_pct(1'b1));
        end
    end

    // ------------------------------------------------------------------
    // Placement monitor: each transfer against the oldest prediction
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin : tile_monitor
        t_placement want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            tiles_seen++;
            if (tiles_due.size() == 0) begin
                flag_error("placement with nothing predicted");
            end else begin
                want = tiles_due.pop_front();
                check_field("draw_x",           out_ch.draw_x,           want.x);
                check_field("draw_y",           out_ch.draw_y,           want.y);
                check_field("tile_map_address", out_ch.tile_map_address, want.addr);
                check_field("palette",          out_ch.palette,          want.pal);
                check_field("flip_x",           out_ch.flip_x,           want.fx);
                check_field("flip_y",           out_ch.flip_y,           want.fy);
                check_field("zoom_x",           out_ch.zoom_x,           want.zx);
                check_field("zoom_y",           out_ch.zoom_y,           want.zy);
                check_field("layer_mask",       out_ch.layer_mask,       want.mask);
                check_field("last_tile",        out_ch.last_tile,        want.last);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------

    initial begin : stimulus
        int unsigned enabled;
        logic        off;

        // known levels on every input from time zero
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.sprite_off = 1'b0;
        in_ch.pos_y_word = '0;
        in_ch.pos_x_word = '0;
        in_ch.style_word = '0;
        in_ch.map_word   = '0;
        out_ch.ready     = 1'b0;

        // directed: disabled sprite with every other bit set, gives nothing
        queue_sprite(1'b1, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        // smallest sprite, no zoom, no priority, map start zero
        queue_sprite(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        // largest sprite: 8x8, full zoom, both flips, top priority, top map address
        queue_sprite(1'b0, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        // one of each priority, assorted sizes and zooms
        queue_sprite(1'b0, {4'h3, 3'd2, 9'h010}, {4'h7, 3'd1, 9'h020}, 16'h1100, 16'h0123);
        queue_sprite(1'b0, {4'h1, 3'd1, 9'h080}, {4'h2, 3'd2, 9'h0c0}, 16'h2a00, 16'h4567);
        queue_sprite(1'b0, {4'h0, 3'd0, 9'h100}, {4'h0, 3'd3, 9'h100}, 16'h3fff, 16'h0001);
        // flip on one axis only: positions reversed, map address still ascending
        queue_sprite(1'b0, {4'h5, 3'd1, 9'h040}, {4'h9, 3'd3, 9'h050}, 16'h4500, 16'h2000);
        queue_sprite(1'b0, {4'ha, 3'd3, 9'h060}, {4'h4, 3'd1, 9'h070}, 16'h8500, 16'h3000);
        // origins at the top of the 9-bit range, wrapping round the screen
        queue_sprite(1'b0, {4'h0, 3'd2, 9'h1ff}, {4'h0, 3'd7, 9'h1ff}, 16'h0800, 16'h1111);
        queue_sprite(1'b0, {4'h6, 3'd1, 9'h1f0}, {4'h6, 3'd2, 9'h1ef}, 16'hc000, 16'h2222);
        queue_sprite(1'b0, 16'h01ff, 16'h0000, 16'h0000, 16'h0000);
        // map start: top bit ignored, then the largest start on the largest sprite
        queue_sprite(1'b0, {4'h2, 3'd1, 9'h030}, {4'h2, 3'd1, 9'h030}, 16'h0000, 16'h8000);
        queue_sprite(1'b0, {4'h0, 3'd7, 9'h000}, {4'h0, 3'd7, 9'h000}, 16'h0000, 16'h7fff);
        // full zoom on a two-tile axis
        queue_sprite(1'b0, {4'hf, 3'd1, 9'h020}, {4'hf, 3'd1, 9'h020}, 16'h1000, 16'h0100);
        // tall thin and wide flat sprites with their flips
        queue_sprite(1'b0, {4'h8, 3'd7, 9'h0a0}, {4'h3, 3'd0, 9'h0b0}, 16'h9c00, 16'h0555);
        queue_sprite(1'b0, {4'h2, 3'd0, 9'h0d0}, {4'hf, 3'd7, 9'h0e0}, 16'h7300, 16'h0aaa);
        // low style byte carries nothing
        queue_sprite(1'b0, 16'h2210, 16'h2210, 16'h00ff, 16'hffff);
        // disabled sprites with random contents
        queue_sprite(1'b1, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        queue_sprite(1'b1, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        queue_pause();

        // random sprites, drained now and then
        enabled = 0;
        while (enabled < RandomSprites) begin
            off = ($urandom_range(99) < 8);
            queue_sprite(off, rand_axis_word(), rand_axis_word(), 16'($urandom), 16'($urandom));
            if (!off) begin
                enabled++;
                if (enabled % PauseEvery == 0)
                    queue_pause();
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every sprite to transfer and every placement to arrive
        while (sprites_taken != sprites_queued)
            @(posedge i_clk);
        while (tiles_due.size() != 0)
            @(posedge i_clk);
        repeat (TailCycles) @(posedge i_clk);

        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> zoomed_sprite_tile_placer_top.f
hdl/zstp_pkg.sv
hdl/zstp_if.sv
hdl/zstp_seq.sv
hdl/zoomed_sprite_tile_placer_top.sv
tb/testbench.sv
